// ----- sv/pot_scanline_digitizer_macros.svh -----
// Assertion macros shared by the pot scanline digitizer RTL.
// Pulled in by the top level; no other dependencies.
`ifndef POT_SCANLINE_DIGITIZER_MACROS_SVH
`define POT_SCANLINE_DIGITIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psd assertion failed");

`endif

// ----- sv/psd_pkg.sv -----
// Package for the pot scanline digitizer: command codes, register indexes,
// fixed widths and the pot bank control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    localparam int LINE_W    = 9;
    localparam int POT_W     = 8;
    localparam int POT_COUNT = 6;
    localparam int CMD_W     = 3;
    localparam int ADDR_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_BTN_READ  = 3'd1,
        CMD_MISC_READ = 3'd2,
        CMD_POT_LATCH = 3'd3,
        CMD_IRQ_ACK   = 3'd4
    } t_cmd;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COINAGE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_TIME = 2'd2;

    localparam logic [BYTE_W-1:0] RST_ROUNDS     = 8'h01;
    localparam logic [BYTE_W-1:0] RST_COINAGE    = 8'h01;
    localparam logic [BYTE_W-1:0] RST_ROUND_TIME = 8'h5c;

    // misc read selects (address bits 1..0)
    localparam logic [1:0] MISC_POT_STATUS = 2'd0;
    localparam logic [1:0] MISC_LINE       = 2'd1;
    localparam logic [1:0] MISC_ROUNDS     = 2'd2;
    localparam logic [1:0] MISC_COINAGE    = 2'd3;

    localparam logic [POT_COUNT-1:0] POT_MASK    = 6'h3f;
    localparam logic [BYTE_W-1:0]    READ_INVERT = 8'h3f;
    localparam logic [BYTE_W-1:0]    TIMER_BIT   = 8'h02;

    typedef logic [POT_COUNT-1:0][POT_W-1:0] t_pots;

    // per-transaction control into the pot bank
    typedef struct packed {
        logic sample;   // tick landing on line 0
        logic compare;  // tick landing on a later line
        logic latch;    // pot latch write
    } t_pot_ctl;

endpackage

`default_nettype wire

// ----- sv/psd_pot_bank.sv -----
// Pot bank: six sampled pot values, reached bits, enable latch and compares.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_pot_bank
    import psd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_pot_ctl             i_ctl,
    input  wire t_pots                i_pots,
    input  wire logic [LINE_W-1:0]    i_line,       // line after this tick
    input  wire logic [POT_COUNT-1:0] i_enable_data,
    output logic      [POT_COUNT-1:0] o_reached,
    output logic      [POT_COUNT-1:0] o_enable,
    output logic                      o_nmi_hit
);

    t_pots                r_sample;
    logic [POT_COUNT-1:0] r_reached;
    logic [POT_COUNT-1:0] r_enable;
    logic [POT_COUNT-1:0] w_hit;

    // six parallel compares against the new line; zero never fires
    always_comb begin
        for (int i = 0; i < POT_COUNT; i++) begin
            w_hit[i] = i_ctl.compare && (r_sample[i] != '0) &&
                       ({1'b0, r_sample[i]} == i_line);
        end
    end

    assign o_nmi_hit = |(w_hit & r_enable);
    assign o_reached = r_reached;
    assign o_enable  = r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample  <= '0;
            r_reached <= '0;
            r_enable  <= '0;
        end else begin
            if (i_ctl.sample) begin
                r_sample  <= i_pots;
                r_reached <= '0;
            end else if (i_ctl.compare) begin
                r_reached <= (r_reached | w_hit) & POT_MASK;
            end
            if (i_ctl.latch) begin
                r_enable <= i_enable_data & POT_MASK;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/pot_scanline_digitizer.sv -----
// Pot scanline digitizer top level. An input transaction passes the input
// register, then the result register, to the result. Throughput: one
// transaction per cycle; both stages advance together when the result slot
// is empty or being taken. Reset (i_rst_n low, synchronous): line 0, pots and
// flags cleared, config registers to 1 / 1 / 0x5c, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module pot_scanline_digitizer
    import psd_pkg::*;
#(
    parameter int LINES_PER_FRAME  = 262,   // 64..511
    parameter int IRQ_LINE_SPACING = 64     // 1..256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [BYTE_W-1:0]    i_cfg_wdata,

    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata, low bit up: pot_h1[7:0], pot_v1[15:8], pot_r1[23:16], pot_h2[31:24],
    // pot_v2[39:32], pot_r2[47:40], address[50:48], write_data[58:51],
    // buttons[66:59], zero pad[71:67]
    input  wire logic [71:0]          s_axis_tdata,
    // tuser: cmd[2:0]
    input  wire logic [CMD_W-1:0]     s_axis_tuser,

    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata, low bit up: read_data[7:0], irq_line[8], nmi_line[9],
    // current_line[18:10], zero pad[23:19]
    output logic      [23:0]          m_axis_tdata
);

    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES_PER_FRAME - 1);
    localparam int IRQ_CNT_W = (IRQ_LINE_SPACING > 1) ? $clog2(IRQ_LINE_SPACING) : 1;
    localparam logic [IRQ_CNT_W-1:0] IRQ_CNT_LAST = IRQ_CNT_W'(IRQ_LINE_SPACING - 1);

    // config registers
    logic [BYTE_W-1:0] r_cfg_rounds;
    logic [BYTE_W-1:0] r_cfg_coinage;
    logic [BYTE_W-1:0] r_cfg_round_time;

    // input stage
    logic                 r_in_valid;
    logic [CMD_W-1:0]     r_cmd;
    t_pots                r_pots;
    logic [ADDR_W-1:0]    r_addr;
    logic [POT_COUNT-1:0] r_wdata;     // only the enable bits matter
    logic [BYTE_W-1:0]    r_buttons;

    // block state
    logic [LINE_W-1:0]    r_line;
    logic [IRQ_CNT_W-1:0] r_irq_cnt;   // r_line modulo the irq spacing
    logic                 r_irq;
    logic                 r_nmi;

    // result stage
    logic                 r_out_valid;
    logic [23:0]          r_out_data;

    logic                 w_adv;
    logic                 w_fire;
    logic [LINE_W-1:0]    w_line_inc;
    logic [IRQ_CNT_W-1:0] w_irq_cnt_inc;
    t_pot_ctl             w_pot_ctl;
    logic [POT_COUNT-1:0] w_reached;
    logic [POT_COUNT-1:0] w_enable;
    logic                 w_nmi_hit;
    logic [BYTE_W-1:0]    w_btn_val;
    logic [BYTE_W-1:0]    w_misc_val;

    logic [LINE_W-1:0]    n_line;
    logic [IRQ_CNT_W-1:0] n_irq_cnt;
    logic                 n_irq;
    logic                 n_nmi;
    logic [BYTE_W-1:0]    n_rd;

    // ---------------- handshake ----------------
    // Result slot frees when empty or taken; the input stage then moves
    // into it, so while results are taken the input side can take a new transaction every cycle.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- line counter ----------------
    assign w_line_inc = (r_line == LINE_LAST) ? '0 : r_line + 1'b1;
    // irq phase counter restarts with the frame so it tracks line modulo spacing
    assign w_irq_cnt_inc = ((w_line_inc == '0) || (r_irq_cnt == IRQ_CNT_LAST)) ?
                           '0 : r_irq_cnt + 1'b1;

    // ---------------- reads ----------------
    // round timer compare uses the current (pre-transaction) line
    assign w_btn_val = r_buttons |
                       (({1'b0, r_cfg_round_time} < r_line) ? TIMER_BIT : '0);

    always_comb begin
        case (r_addr[1:0])
            MISC_POT_STATUS: w_misc_val = {2'b00, w_reached & w_enable};
            MISC_LINE:       w_misc_val = r_line[BYTE_W-1:0];
            MISC_ROUNDS:     w_misc_val = r_cfg_rounds;
            MISC_COINAGE:    w_misc_val = r_cfg_coinage;
            default:         w_misc_val = r_cfg_coinage;
        endcase
    end

    // ---------------- command decode / next state ----------------
    always_comb begin
        n_line    = r_line;
        n_irq_cnt = r_irq_cnt;
        n_irq     = r_irq;
        n_nmi     = r_nmi;
        n_rd      = '0;
        w_pot_ctl = '0;
        case (t_cmd'(r_cmd))
            CMD_TICK: begin
                n_line    = w_line_inc;
                n_irq_cnt = w_irq_cnt_inc;
                if (w_irq_cnt_inc == '0) begin
                    n_irq = 1'b1;
                end
                w_pot_ctl.sample  = w_fire && (w_line_inc == '0);
                w_pot_ctl.compare = w_fire && (w_line_inc != '0);
                if (w_nmi_hit) begin
                    n_nmi = 1'b1;
                end
            end
            CMD_BTN_READ: begin
                n_rd = {w_btn_val[r_addr], {(BYTE_W-1){1'b0}}};
            end
            CMD_MISC_READ: begin
                n_rd = w_misc_val ^ READ_INVERT;
            end
            CMD_POT_LATCH: begin
                w_pot_ctl.latch = w_fire;
                n_nmi           = 1'b0;
            end
            CMD_IRQ_ACK: begin
                n_irq = 1'b0;
            end
            default: begin
                // unused commands change nothing
            end
        endcase
    end

    psd_pot_bank u_pot_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_pot_ctl),
        .i_pots        (r_pots),
        .i_line        (w_line_inc),
        .i_enable_data (r_wdata),
        .o_reached     (w_reached),
        .o_enable      (w_enable),
        .o_nmi_hit     (w_nmi_hit)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rounds     <= RST_ROUNDS;
            r_cfg_coinage    <= RST_COINAGE;
            r_cfg_round_time <= RST_ROUND_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROUNDS:     r_cfg_rounds     <= i_cfg_wdata;
                CFG_COINAGE:    r_cfg_coinage    <= i_cfg_wdata;
                CFG_ROUND_TIME: r_cfg_round_time <= i_cfg_wdata;
                default: begin
                    // index past the list: ignored
                end
            endcase
        end
    end

    // input stage payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_cmd     <= s_axis_tuser;
            r_pots    <= s_axis_tdata[47:0];
            r_addr    <= s_axis_tdata[50:48];
            r_wdata   <= s_axis_tdata[56:51];
            r_buttons <= s_axis_tdata[66:59];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {5'b0, n_line, n_nmi, n_irq, n_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= '0;
            r_irq_cnt   <= '0;
            r_irq       <= 1'b0;
            r_nmi       <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_line    <= n_line;
                r_irq_cnt <= n_irq_cnt;
                r_irq     <= n_irq;
                r_nmi     <= n_nmi;
            end
        end
    end

    // ---------------- assertions ----------------
`include "pot_scanline_digitizer_macros.svh"

    `PSD_ASSERT_IMP(a_line_in_frame, i_clk, i_rst_n, 1'b1, (r_line <= LINE_LAST))
    `PSD_ASSERT_IMP(a_irq_phase_frame, i_clk, i_rst_n, (r_line == '0), (r_irq_cnt == '0))
    `PSD_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, (r_in_valid && !w_adv), r_in_valid)

endmodule

`default_nettype wire

// ----- tb/pot_scanline_digitizer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pot_scanline_digitizer: stream stimulus, a scoreboard
// class that tracks raster/pot/interrupt state, and register writes between phases.
// Depends on psd_pkg and the pot_scanline_digitizer RTL only.

module pot_scanline_digitizer_tb;
    import psd_pkg::*;

    localparam int FRAME_LINES    = 262;
    localparam int IRQ_SPACING    = 64;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 6;     // pipeline is 2 deep, leave some slack
    localparam int PHASE_ITEMS    = 192;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int STALL_LIMIT    = 2000;

    // tuser codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    // s_axis_tdata layout, low bits last in the struct
    typedef struct packed {
        logic [4:0]        pad;
        logic [BYTE_W-1:0] buttons;
        logic [BYTE_W-1:0] wr_data;
        logic [ADDR_W-1:0] addr;
        t_pots             pots;       // pots[0] = h1 ... pots[5] = r2
    } t_stick_item;

    // m_axis_tdata layout
    typedef struct packed {
        logic [4:0]        pad;
        logic [LINE_W-1:0] line;
        logic              nmi;
        logic              irq;
        logic [BYTE_W-1:0] read_data;
    } t_line_result;

    // ------------------------------------------------------------------
    // Scoreboard: private copy of the raster state, predicts one result
    // per accepted transaction and checks results in order.
    // ------------------------------------------------------------------
    class line_checker;
        logic [BYTE_W-1:0]    rounds_sw;
        logic [BYTE_W-1:0]    coinage_sw;
        logic [BYTE_W-1:0]    round_time;
        logic [LINE_W-1:0]    line;
        t_pots                pot_val;
        logic [POT_COUNT-1:0] reached;
        logic [POT_COUNT-1:0] enable;
        logic                 irq;
        logic                 nmi;
        t_line_result         expected_results[$];
        int                   errors;

        function new();
            rounds_sw  = RST_ROUNDS;
            coinage_sw = RST_COINAGE;
            round_time = RST_ROUND_TIME;
            line       = '0;
            pot_val    = '0;
            reached    = '0;
            enable     = '0;
            irq        = 1'b0;
            nmi        = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                CFG_ROUNDS:     rounds_sw  = val;
                CFG_COINAGE:    coinage_sw = val;
                CFG_ROUND_TIME: round_time = val;
                default: ;
            endcase
        endfunction

        function t_line_result digitize_step(logic [CMD_W-1:0] cmd, t_stick_item it);
            t_line_result res;
            logic [BYTE_W-1:0] v;
            int i;
            res = '0;
            v   = '0;
            case (cmd)
                CMD_TICK: begin
                    // advance first, then act on the new line
                    line = (line == FRAME_LINES - 1) ? '0 : line + 1'b1;
                    if (line % IRQ_SPACING == 0)
                        irq = 1'b1;
                    if (line == 0) begin
                        pot_val = it.pots;
                        reached = '0;
                    end else begin
                        // each pot fires on its own; a zero pot never fires
                        for (i = 0; i < POT_COUNT; i++) begin
                            if (pot_val[i] != 0 && pot_val[i] == line) begin
                                reached[i] = 1'b1;
                                if (enable[i])
                                    nmi = 1'b1;
                            end
                        end
                    end
                end
                CMD_BTN_READ: begin
                    v = it.buttons;
                    if (round_time < line)
                        v = v | TIMER_BIT;
                    res.read_data = {v[it.addr], 7'b0};
                end
                CMD_MISC_READ: begin
                    case (it.addr[1:0])     // address bit 2 is a don't-care
                        MISC_POT_STATUS: v = {2'b00, reached & enable};
                        MISC_LINE:       v = line[BYTE_W-1:0];
                        MISC_ROUNDS:     v = rounds_sw;
                        MISC_COINAGE:    v = coinage_sw;
                        default: ;
                    endcase
                    res.read_data = v ^ READ_INVERT;
                end
                CMD_POT_LATCH: begin
                    enable = it.wr_data[POT_COUNT-1:0] & POT_MASK;
                    nmi    = 1'b0;
                end
                CMD_IRQ_ACK: irq = 1'b0;
                default: ;
            endcase
            res.irq  = irq;
            res.nmi  = nmi;
            res.line = line;
            return res;
        endfunction

        function void note_transaction(logic [CMD_W-1:0] cmd, logic [71:0] raw);
            expected_results.push_back(digitize_step(cmd, t_stick_item'(raw)));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] raw);
            t_line_result got;
            t_line_result want;
            got = raw;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no transaction pending: expected none actual %h",
                         $time, raw);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("irq_line", want.irq, got.irq);
            compare_field("nmi_line", want.nmi, got.nmi);
            compare_field("current_line", want.line, got.line);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [BYTE_W-1:0]    i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [71:0]          s_axis_tdata  = '0;   // pots h1..r2, address, write_data, buttons
    logic [CMD_W-1:0]     s_axis_tuser  = '0;   // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;         // read_data, irq, nmi, current_line

    pot_scanline_digitizer #(
        .LINES_PER_FRAME  (FRAME_LINES),
        .IRQ_LINE_SPACING (IRQ_SPACING)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    line_checker sb;
    int          send_idle_pct = 8;     // % of cycles the source holds tvalid low
    int          recv_idle_pct = 69;    // % of cycles the sink holds tready low
    logic        rx_hold_go    = 1'b0;  // one-shot request for a long sink stall
    int          hold_left     = 0;
    logic        hold_done     = 1'b0;
    int          stall_cycles  = 0;

    // Sink side: random backpressure, plus one long hold-off so the
    // two-stage pipe fills and tready drops on the input.
    always @(posedge i_clk) begin
        if (rx_hold_go && !hold_done) begin
            hold_left = RX_HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor both sides at the edge (pre-update values), plus the
    // watchdog on cycles with no transaction at all.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_transaction(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("pot_scanline_digitizer_tb NOT OK");
                $finish;
            end
        end
    end

    // Offer one transaction, with random gaps ahead of it; returns on accept.
    task automatic send(input logic [CMD_W-1:0] cmd, input t_stick_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= it;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_stick_item build_item(logic [ADDR_W-1:0] addr,
                                               logic [BYTE_W-1:0] wr_data,
                                               logic [BYTE_W-1:0] buttons,
                                               t_pots pots);
        t_stick_item it;
        it         = '0;
        it.addr    = addr;
        it.wr_data = wr_data;
        it.buttons = buttons;
        it.pots    = pots;
        return it;
    endfunction

    // Mostly ticks so the line counter advances and the pots get to fire.
    // Pots: some zero, some maxed, sometimes several sharing one line.
    task automatic random_burst(input int count);
        t_stick_item      it;
        logic [CMD_W-1:0] cmd;
        int unsigned      pick;
        logic [BYTE_W-1:0] shared;
        int n;
        int i;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 78)      cmd = CMD_TICK;
            else if (pick < 84) cmd = CMD_BTN_READ;
            else if (pick < 90) cmd = CMD_MISC_READ;
            else if (pick < 94) cmd = CMD_POT_LATCH;
            else if (pick < 98) cmd = CMD_IRQ_ACK;
            else                cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            it = build_item(ADDR_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                            BYTE_W'($urandom_range(0, 255)), '0);
            shared = BYTE_W'($urandom_range(1, 255));
            for (i = 0; i < POT_COUNT; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)      it.pots[i] = '0;
                else if (pick < 15) it.pots[i] = 8'hff;
                else if (pick < 30) it.pots[i] = shared;
                else                it.pots[i] = POT_W'($urandom_range(0, 255));
            end
            send(cmd, it);
        end
    endtask

    // Drop tvalid and let everything outstanding come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Block is idle here; write all three switch/timer registers.
    task automatic apply_settings(input logic [BYTE_W-1:0] rounds,
                                  input logic [BYTE_W-1:0] coinage,
                                  input logic [BYTE_W-1:0] round_time);
        logic [BYTE_W-1:0]    vals[3];
        logic [CFG_IDX_W-1:0] idx[3];
        int k;
        vals = '{rounds, coinage, round_time};
        idx  = '{CFG_ROUNDS, CFG_COINAGE, CFG_ROUND_TIME};
        for (k = 0; k < 3; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            sb.set_reg(idx[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int a;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values of every register, every read select,
        // all button bits, enable masking, ignored commands.
        send(CMD_MISC_READ, build_item({1'b0, MISC_POT_STATUS}, '0, '0, '0));
        send(CMD_MISC_READ, build_item({1'b0, MISC_LINE}, '0, '0, '0));
        send(CMD_MISC_READ, build_item({1'b0, MISC_ROUNDS}, '0, '0, '0));
        send(CMD_MISC_READ, build_item({1'b0, MISC_COINAGE}, '0, '0, '0));
        send(CMD_MISC_READ, build_item({1'b1, MISC_ROUNDS}, '1, '1, '1));  // addr bit 2 ignored
        for (a = 0; a < 8; a++)
            send(CMD_BTN_READ, build_item(a[ADDR_W-1:0], '0, 8'hff, '0));
        send(CMD_BTN_READ, build_item(3'd1, '0, 8'h00, '0));  // timer bit not forced on line 0
        send(CMD_POT_LATCH, build_item('0, 8'hff, '0, '0));
        send(CMD_TICK, build_item('1, '1, '1, '1));           // pots ignored off line 0
        send(CMD_TICK, build_item('0, '0, '0, '0));
        send(CMD_MISC_READ, build_item({1'b0, MISC_POT_STATUS}, '0, '0, '0));
        send(CMD_IRQ_ACK, build_item('0, '0, '0, '0));
        send(CMD_UNUSED_FIRST, build_item('1, '1, '1, '1));
        send(CMD_UNUSED_LAST, build_item('1, '1, '1, '1));
        send(CMD_POT_LATCH, build_item('0, 8'hc0, '0, '0));   // upper bits masked off
        settle();

        // Phase 1: low extremes, mostly-ready source, slow sink.
        apply_settings(8'h00, 8'hff, 8'h00);
        random_burst(PHASE_ITEMS);
        settle();

        // Phase 2: high extremes, slow source, mostly-ready sink.
        send_idle_pct = 69;
        recv_idle_pct <= 8;
        apply_settings(8'hff, 8'h00, 8'hff);
        random_burst(PHASE_ITEMS);
        settle();

        // Phase 3: random settings, no idling, one long sink hold-off.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        apply_settings(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)));
        rx_hold_go <= 1'b1;
        random_burst(PHASE_ITEMS);
        settle();

        if (sb.errors == 0)
            $display("pot_scanline_digitizer_tb OK");
        else
            $display("pot_scanline_digitizer_tb NOT OK");
        $finish;
    end

endmodule
